/* rtl/stvk_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stvk_pkg
// Shared types and constants for the St. Venant-Kirchhoff stress pipeline.
// ----------------------------------------------------------------------------
package stvk_pkg;

    // operand chunk width of the split multipliers
    localparam int CHUNK_W = 32;

    // load enables of the two register stages inside one split multiplier
    typedef struct packed {
        logic load_pp;   // partial products
        logic load_p;    // summed product
    } t_mul_en;

endpackage

/* rtl/stvk_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stvk_mul
// Two-stage signed multiplier: 33x33 partial products, then one sum.
// ----------------------------------------------------------------------------
module stvk_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic                     i_clk,
    input  stvk_pkg::t_mul_en        i_en,
    input  logic signed [WA-1:0]     i_a,
    input  logic signed [WB-1:0]     i_b,
    output logic signed [WA+WB-1:0]  o_p
);
    localparam int CW  = stvk_pkg::CHUNK_W;
    localparam int NA  = (WA + CW - 1) / CW;
    localparam int NB  = (WB + CW - 1) / CW;
    localparam int WXA = NA * CW;
    localparam int WXB = NB * CW;
    localparam int WS  = (NA + NB) * CW + CW;
    localparam int WP  = 2 * CW + 2;

    logic signed [WXA-1:0]    w_ax;
    logic signed [WXB-1:0]    w_bx;
    logic signed [CW:0]       w_ac [NA];
    logic signed [CW:0]       w_bc [NB];
    logic signed [WP-1:0]     r_pp [NA*NB];
    logic signed [WS-1:0]     n_sum;
    logic signed [WA+WB-1:0]  r_p;

    assign w_ax = WXA'(i_a);
    assign w_bx = WXB'(i_b);

    // low chunks unsigned, top chunk carries the sign
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            w_ac[i] = {((i == NA - 1) ? w_ax[WXA-1] : 1'b0), w_ax[i*CW +: CW]};
        end
        for (int j = 0; j < NB; j++) begin
            w_bc[j] = {((j == NB - 1) ? w_bx[WXB-1] : 1'b0), w_bx[j*CW +: CW]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load_pp) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i*NB+j] <= WP'(w_ac[i]) * WP'(w_bc[j]);
                end
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                n_sum = n_sum + (WS'(r_pp[i*NB+j]) <<< (CW * (i + j)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load_p) begin
            r_p <= n_sum[WA+WB-1:0];
        end
    end

    assign o_p = r_p;

endmodule

/* rtl/stvk_stress_and_energy.sv */
`timescale 1ns / 1ps
// Throughput: one transfer per cycle while the output is not stalled; twelve
// register stages with a valid bit each, and a stage loads whenever it is empty
// or the next one moves.
// Wide products use two-stage split multipliers (33x33 partial products).
// Reset (synchronous, active low) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// stvk_stress_and_energy
// First Piola-Kirchhoff stress and strain energy of one StVK tetrahedron.
// ----------------------------------------------------------------------------
module stvk_stress_and_energy (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [31:0]  i_f00,
    input  logic signed [31:0]  i_f01,
    input  logic signed [31:0]  i_f02,
    input  logic signed [31:0]  i_f10,
    input  logic signed [31:0]  i_f11,
    input  logic signed [31:0]  i_f12,
    input  logic signed [31:0]  i_f20,
    input  logic signed [31:0]  i_f21,
    input  logic signed [31:0]  i_f22,
    input  logic [31:0]         i_shear_modulus,
    input  logic [31:0]         i_lame_lambda,
    input  logic [31:0]         i_rest_volume,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [47:0]  o_p00,
    output logic signed [47:0]  o_p01,
    output logic signed [47:0]  o_p02,
    output logic signed [47:0]  o_p10,
    output logic signed [47:0]  o_p11,
    output logic signed [47:0]  o_p12,
    output logic signed [47:0]  o_p20,
    output logic signed [47:0]  o_p21,
    output logic signed [47:0]  o_p22,
    output logic [62:0]         o_strain_energy
);
    // Stage plan (value available in the register of stage n):
    //   1  F^T F partial products (32x32)
    //   2  Green strain E, six unique entries (E is symmetric), Q24
    //   3  trace; F*E and E*E multipliers running
    //   4  F*E, E*E products
    //   5  FE (Q32), sum of squares ss (Q24); tr*lambda, tr*tr products
    //   6  lambda*tr (Q24), tr^2/2 (Q24)
    //   7  G*FE, G*ss products
    //   8  lt*F, lambda*th products
    //   9  stress sum in Q48, energy density w0
    //  10  stress rounded and saturated; w0*V running
    //  11  w0*V product
    //  12  output register, energy rounded and saturated
    localparam int NSTG = 12;

    // symmetric E storage: entry index of E[i][j]
    localparam int EMAP [9] = '{0, 1, 2, 1, 3, 4, 2, 4, 5};
    localparam int EI   [6] = '{0, 0, 0, 1, 1, 2};
    localparam int EJ   [6] = '{0, 1, 2, 1, 2, 2};

    localparam logic signed [47:0] PMAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] PMIN = {1'b1, {47{1'b0}}};

    // ---------------- handshake / stage control ----------------
    logic [NSTG:1]   r_v;
    logic [NSTG+1:1] w_adv;

    // a stage moves when it is empty or its successor moves
    always_comb begin
        w_adv[NSTG+1] = i_out_ready;
        for (int k = NSTG; k >= 1; k--) begin
            w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[1]) begin
                r_v[1] <= i_in_valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (w_adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_in_ready  = w_adv[1];
    assign o_out_valid = r_v[NSTG];

    // multiplier enables: operands in stage n, result in stage n+2
    stvk_pkg::t_mul_en w_men2, w_men3, w_men5, w_men6, w_men9;
    assign w_men2 = '{load_pp: w_adv[3],  load_p: w_adv[4]};
    assign w_men3 = '{load_pp: w_adv[4],  load_p: w_adv[5]};
    assign w_men5 = '{load_pp: w_adv[6],  load_p: w_adv[7]};
    assign w_men6 = '{load_pp: w_adv[7],  load_p: w_adv[8]};
    assign w_men9 = '{load_pp: w_adv[10], load_p: w_adv[11]};

    // ---------------- operand delay lines ----------------
    logic signed [31:0] w_f [9];
    logic signed [31:0] r_f   [1:6][9];
    logic [31:0]        r_g   [1:5];
    logic [31:0]        r_lam [1:6];
    logic [31:0]        r_vol [1:9];

    assign w_f = '{i_f00, i_f01, i_f02, i_f10, i_f11, i_f12, i_f20, i_f21, i_f22};

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_f[1]   <= w_f;
            r_g[1]   <= i_shear_modulus;
            r_lam[1] <= i_lame_lambda;
            r_vol[1] <= i_rest_volume;
        end
        for (int k = 2; k <= 6; k++) begin
            if (w_adv[k]) begin
                r_f[k]   <= r_f[k-1];
                r_lam[k] <= r_lam[k-1];
            end
        end
        for (int k = 2; k <= 5; k++) begin
            if (w_adv[k]) begin
                r_g[k] <= r_g[k-1];
            end
        end
        for (int k = 2; k <= 9; k++) begin
            if (w_adv[k]) begin
                r_vol[k] <= r_vol[k-1];
            end
        end
    end

    // ---------------- stage 1: F^T F products ----------------
    logic signed [63:0] r_pf [6][3];

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            for (int n = 0; n < 6; n++) begin
                for (int k = 0; k < 3; k++) begin
                    r_pf[n][k] <= 64'(w_f[k*3+EI[n]]) * 64'(w_f[k*3+EJ[n]]);
                end
            end
        end
    end

    // ---------------- stage 2: Green strain ----------------
    logic signed [66:0] n_eacc [6];
    logic signed [40:0] r_e    [6];

    // E = (C - I)/2 in Q24: subtract one (Q48) on the diagonal, round at bit 25
    always_comb begin
        for (int n = 0; n < 6; n++) begin
            n_eacc[n] = 67'(r_pf[n][0]) + 67'(r_pf[n][1]) + 67'(r_pf[n][2])
                      + (67'(1) << 24);
            if (EI[n] == EJ[n]) begin
                n_eacc[n] = n_eacc[n] - (67'(1) << 48);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            for (int n = 0; n < 6; n++) begin
                r_e[n] <= n_eacc[n][65:25];
            end
        end
    end

    // ---------------- stage 3: trace; F*E and E*E ----------------
    logic signed [42:0] r_tr;

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r_tr <= 43'(r_e[0]) + 43'(r_e[3]) + 43'(r_e[5]);
        end
    end

    logic signed [72:0] w_fe_pp [9][3];
    logic signed [81:0] w_ee_pp [6];

    for (genvar gi = 0; gi < 3; gi++) begin : g_fe_row
        for (genvar gj = 0; gj < 3; gj++) begin : g_fe_col
            for (genvar gk = 0; gk < 3; gk++) begin : g_fe_term
                stvk_mul #(.WA(32), .WB(41)) u_mul (
                    .i_clk (i_clk),
                    .i_en  (w_men2),
                    .i_a   (r_f[2][gi*3+gk]),
                    .i_b   (r_e[EMAP[gk*3+gj]]),
                    .o_p   (w_fe_pp[gi*3+gj][gk])
                );
            end
        end
    end

    for (genvar gn = 0; gn < 6; gn++) begin : g_ee
        stvk_mul #(.WA(41), .WB(41)) u_mul (
            .i_clk (i_clk),
            .i_en  (w_men2),
            .i_a   (r_e[gn]),
            .i_b   (r_e[gn]),
            .o_p   (w_ee_pp[gn])
        );
    end

    // tr * lambda and tr * tr, operands in stage 3
    logic signed [75:0] w_trlam;
    logic signed [85:0] w_trtr;

    stvk_mul #(.WA(43), .WB(33)) u_mul_trlam (
        .i_clk (i_clk),
        .i_en  (w_men3),
        .i_a   (r_tr),
        .i_b   ({1'b0, r_lam[3]}),
        .o_p   (w_trlam)
    );

    stvk_mul #(.WA(43), .WB(43)) u_mul_trtr (
        .i_clk (i_clk),
        .i_en  (w_men3),
        .i_a   (r_tr),
        .i_b   (r_tr),
        .o_p   (w_trtr)
    );

    // ---------------- stage 5: FE and ss ----------------
    logic signed [75:0] n_fes [9];
    logic [85:0]        n_sss;
    logic signed [58:0] r_fe  [9];
    logic [60:0]        r_ss;

    always_comb begin
        for (int n = 0; n < 9; n++) begin
            n_fes[n] = 76'(w_fe_pp[n][0]) + 76'(w_fe_pp[n][1]) + 76'(w_fe_pp[n][2])
                     + (76'(1) << 15);
        end
        // off-diagonal squares count twice
        n_sss = 86'(1) << 23;
        for (int n = 0; n < 6; n++) begin
            if (EI[n] == EJ[n]) begin
                n_sss = n_sss + 86'(w_ee_pp[n]);
            end else begin
                n_sss = n_sss + (86'(w_ee_pp[n]) << 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            for (int n = 0; n < 9; n++) begin
                r_fe[n] <= n_fes[n][74:16];
            end
            r_ss <= n_sss[84:24];
        end
    end

    // ---------------- stage 6: lt and th ----------------
    logic signed [76:0] n_lts;
    logic signed [86:0] n_ths;
    logic signed [59:0] r_lt;
    logic [60:0]        r_th;

    assign n_lts = 77'(w_trlam) + (77'(1) << 15);
    assign n_ths = 87'(w_trtr) + (87'(1) << 24);

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r_lt <= n_lts[75:16];
            r_th <= n_ths[85:25];
        end
    end

    // G*FE and G*ss from stage 5; lt*F and lambda*th from stage 6
    logic signed [91:0] w_gfe [9];
    logic signed [91:0] w_ltf [9];
    logic signed [94:0] w_gss;
    logic signed [94:0] w_lamth;

    for (genvar gn = 0; gn < 9; gn++) begin : g_pmul
        stvk_mul #(.WA(33), .WB(59)) u_mul_gfe (
            .i_clk (i_clk),
            .i_en  (w_men5),
            .i_a   ({1'b0, r_g[5]}),
            .i_b   (r_fe[gn]),
            .o_p   (w_gfe[gn])
        );
        stvk_mul #(.WA(60), .WB(32)) u_mul_ltf (
            .i_clk (i_clk),
            .i_en  (w_men6),
            .i_a   (r_lt),
            .i_b   (r_f[6][gn]),
            .o_p   (w_ltf[gn])
        );
    end

    stvk_mul #(.WA(33), .WB(62)) u_mul_gss (
        .i_clk (i_clk),
        .i_en  (w_men5),
        .i_a   ({1'b0, r_g[5]}),
        .i_b   ({1'b0, r_ss}),
        .o_p   (w_gss)
    );

    stvk_mul #(.WA(33), .WB(62)) u_mul_lamth (
        .i_clk (i_clk),
        .i_en  (w_men6),
        .i_a   ({1'b0, r_lam[6]}),
        .i_b   ({1'b0, r_th}),
        .o_p   (w_lamth)
    );

    // ---------------- stage 8: align stage-7 products ----------------
    logic signed [91:0] r_gfe8 [9];
    logic signed [94:0] r_gss8;

    always_ff @(posedge i_clk) begin
        if (w_adv[8]) begin
            r_gfe8 <= w_gfe;
            r_gss8 <= w_gss;
        end
    end

    // ---------------- stage 9: stress sum, energy density ----------------
    logic signed [93:0] r_a  [9];
    logic signed [95:0] r_w0;

    always_ff @(posedge i_clk) begin
        if (w_adv[9]) begin
            for (int n = 0; n < 9; n++) begin
                r_a[n] <= (94'(r_gfe8[n]) <<< 1) + 94'(w_ltf[n]);
            end
            r_w0 <= 96'(r_gss8) + 96'(w_lamth);
        end
    end

    // volume weighting, operands in stage 9
    logic signed [128:0] w_wv;

    stvk_mul #(.WA(96), .WB(33)) u_mul_vol (
        .i_clk (i_clk),
        .i_en  (w_men9),
        .i_a   (r_w0),
        .i_b   ({1'b0, r_vol[9]}),
        .o_p   (w_wv)
    );

    // ---------------- stage 10: stress round and saturate ----------------
    logic signed [94:0] n_ps  [9];
    logic signed [47:0] n_p10 [9];
    logic signed [47:0] r_p10 [9];
    logic signed [47:0] r_p11 [9];
    logic signed [47:0] r_p12 [9];

    // in range when bits 94..71 of the rounded sum all match the sign of bit 71
    always_comb begin
        for (int n = 0; n < 9; n++) begin
            n_ps[n] = 95'(r_a[n]) + (95'(1) << 23);
            if ((&n_ps[n][94:71]) || !(|n_ps[n][94:71])) begin
                n_p10[n] = n_ps[n][71:24];
            end else if (n_ps[n][94]) begin
                n_p10[n] = PMIN;
            end else begin
                n_p10[n] = PMAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[10]) begin
            r_p10 <= n_p10;
        end
        if (w_adv[11]) begin
            r_p11 <= r_p10;
        end
        if (w_adv[12]) begin
            r_p12 <= r_p11;
        end
    end

    // ---------------- stage 12: energy round and saturate ----------------
    logic [129:0] n_ens;
    logic [62:0]  n_energy;
    logic [62:0]  r_energy;

    // product is never negative; clamp to all ones above 63 bits
    always_comb begin
        n_ens = 130'(w_wv) + (130'(1) << 31);
        if (|n_ens[129:95]) begin
            n_energy = '1;
        end else begin
            n_energy = n_ens[94:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[12]) begin
            r_energy <= n_energy;
        end
    end

    assign o_p00 = r_p12[0];
    assign o_p01 = r_p12[1];
    assign o_p02 = r_p12[2];
    assign o_p10 = r_p12[3];
    assign o_p11 = r_p12[4];
    assign o_p12 = r_p12[5];
    assign o_p20 = r_p12[6];
    assign o_p21 = r_p12[7];
    assign o_p22 = r_p12[8];
    assign o_strain_energy = r_energy;

    // ---------------- assertions ----------------
    // an accepted transfer always lands in stage 1
    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_v[1])
        else $error("accepted input did not enter stage 1");

    // a full pipeline facing a stalled sink takes nothing in
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_v) && !i_out_ready) |-> !o_in_ready)
        else $error("input ready while pipeline full and stalled");

    // an empty stage never blocks the input side
    a_bubble_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(&r_v)) |-> o_in_ready)
        else $error("input stalled although a stage is empty");

    // reset empties the pipeline
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule
